[src/pmt_pkg.sv]
// shared types, constants and register codes of the preshape memory trace
package pmt_pkg;

  localparam int IDX_W             = 12;
  localparam int DATA_W            = 16;
  localparam int TIME_W            = 16;
  localparam int CFG_IDX_W         = 4;
  localparam int FIELD_ENTRIES_DEF = 4096;

  // rate and sigmoid are unsigned q0.16 with 1.0 representable
  localparam int RATE_W = 17;
  // rate times sigmoid product, up to 2^32
  localparam int K_W    = 33;

  localparam logic [15:0] BUILD_UP_RST  = 16'd100;
  localparam logic [15:0] DECAY_RST     = 16'd1000;
  localparam logic [15:0] THRESHOLD_RST = 16'd128;
  localparam logic [15:0] STEEPNESS_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUILD_UP  = 4'd0,
    REG_DECAY     = 4'd1,
    REG_THRESHOLD = 4'd2,
    REG_STEEPNESS = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef struct packed {
    logic [15:0]        build_up;
    logic [15:0]        decay;
    logic signed [15:0] threshold;
    logic [15:0]        steepness;
  } cfg_t;

  // word leaving the sigmoid and rate pipeline
  typedef struct packed {
    logic                     valid;
    op_e                      op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] p;
    logic [K_W-1:0]           ku;
    logic [K_W-1:0]           kd;
  } front_t;

  typedef struct packed {
    logic adv;
    logic hazard;
    logic clr_done;
  } ctl_t;

endpackage

[src/pmt_if.sv]
// channel interfaces: update input, result output, register write
interface pmt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [pmt_pkg::IDX_W-1:0]        entry_index;
  logic signed [pmt_pkg::DATA_W-1:0] input_value;
  logic signed [pmt_pkg::DATA_W-1:0] peak_gain;
  logic [pmt_pkg::TIME_W-1:0]       step_time_us;
  modport source(output valid, op, entry_index, input_value, peak_gain, step_time_us,
                 input ready);
  modport sink(input valid, op, entry_index, input_value, peak_gain, step_time_us,
               output ready);
endinterface

interface pmt_out_if;
  logic                             valid;
  logic                             ready;
  logic [pmt_pkg::IDX_W-1:0]        result_index;
  logic signed [pmt_pkg::DATA_W-1:0] new_activation;
  modport source(output valid, result_index, new_activation, input ready);
  modport sink(input valid, result_index, new_activation, output ready);
endinterface

interface pmt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pmt_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/pmt_ram.sv]
// generic single write port ram with registered read
module pmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pmt_divpipe.sv]
// restoring divider, one quotient bit per pipeline stage
module pmt_divpipe #(
  parameter int DW = 33,
  parameter int QW = 16,
  localparam int RW = DW + QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] sh;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign sh = RW'(den_in) << K;
    assign ge = (rem_in >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_in - sh) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (ge ? (QW'(1) << K) : '0);
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[src/pmt_front.sv]
// sigmoid and rate pipeline, independent of the stored activation
module pmt_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  pmt_pkg::op_e                     in_op_i,
  input  logic [pmt_pkg::IDX_W-1:0]        in_idx_i,
  input  logic signed [pmt_pkg::DATA_W-1:0] in_x_i,
  input  logic signed [pmt_pkg::DATA_W-1:0] in_p_i,
  input  logic [pmt_pkg::TIME_W-1:0]       in_dt_i,
  input  pmt_pkg::cfg_t                    cfg_i,
  output pmt_pkg::front_t                  fo_o
);

  localparam int QW  = 16;
  localparam int QDW = 33;
  localparam int RDW = 26;

  typedef struct packed {
    pmt_pkg::op_e                     op;
    logic [pmt_pkg::IDX_W-1:0]        idx;
    logic signed [pmt_pkg::DATA_W-1:0] x;
    logic signed [pmt_pkg::DATA_W-1:0] p;
    logic                             neg;
    logic                             sat_u;
    logic                             sat_d;
  } meta_t;

  // input register
  logic                             f0_v_q;
  pmt_pkg::op_e                     f0_op_q;
  logic [pmt_pkg::IDX_W-1:0]        f0_idx_q;
  logic signed [pmt_pkg::DATA_W-1:0] f0_x_q, f0_p_q;
  logic [pmt_pkg::TIME_W-1:0]       f0_dt_q;
  logic signed [16:0]               d;
  logic                             f0_neg;
  logic [15:0]                      f0_absd;

  // |x - t|
  logic                             f1_v_q;
  meta_t                            f1_m_q;
  logic [pmt_pkg::TIME_W-1:0]       f1_dt_q;
  logic [15:0]                      f1_absd_q;

  // b*|x - t|
  logic                             f2_v_q;
  meta_t                            f2_m_q;
  logic [pmt_pkg::TIME_W-1:0]       f2_dt_q;
  logic [31:0]                      f2_prod_q;
  logic [RDW-1:0]                   tu, td;

  // divider operands
  logic                             f3_v_q;
  meta_t                            f3_m_q;
  logic [QDW+QW-1:0]                f3_qnum_q;
  logic [QDW-1:0]                   f3_qden_q;
  logic [RDW+QW-1:0]                f3_rnum_q;
  logic [RDW-1:0]                   f3_tu_q, f3_td_q;

  logic                             dv_q [QW];
  meta_t                            dm_q [QW];
  logic [QW-1:0]                    q_quo, ru_quo, rd_quo;

  // sigmoid and rates
  logic                             f4_v_q;
  meta_t                            f4_m_q;
  logic [pmt_pkg::RATE_W-1:0]       f4_s_q, f4_c_q, f4_ru_q, f4_rd_q;
  logic [pmt_pkg::RATE_W-1:0]       s_d, ru_d, rd_d;
  logic [33:0]                      ku_full, kd_full;

  // rate times sigmoid products
  logic                             f5_v_q;
  meta_t                            f5_m_q;
  logic [pmt_pkg::K_W-1:0]          f5_ku_q, f5_kd_q;

  assign d       = 17'(f0_x_q) - 17'(cfg_i.threshold);
  assign f0_neg  = d[16];
  assign f0_absd = f0_neg ? 16'(-d) : 16'(d);

  assign tu = RDW'(cfg_i.build_up) * RDW'(1000);
  assign td = RDW'(cfg_i.decay) * RDW'(1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
      f5_v_q <= 1'b0;
      for (int i = 0; i < QW; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      f0_v_q <= in_valid_i;
      f1_v_q <= f0_v_q;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      dv_q[0] <= f3_v_q;
      for (int i = 1; i < QW; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      f4_v_q <= dv_q[QW-1];
      f5_v_q <= f4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f0_op_q  <= in_op_i;
      f0_idx_q <= in_idx_i;
      f0_x_q   <= in_x_i;
      f0_p_q   <= in_p_i;
      f0_dt_q  <= in_dt_i;

      f1_m_q    <= '{op: f0_op_q, idx: f0_idx_q, x: f0_x_q, p: f0_p_q, neg: f0_neg,
                     sat_u: 1'b0, sat_d: 1'b0};
      f1_dt_q   <= f0_dt_q;
      f1_absd_q <= f0_absd;

      f2_m_q    <= f1_m_q;
      f2_dt_q   <= f1_dt_q;
      f2_prod_q <= 32'(cfg_i.steepness) * 32'(f1_absd_q);

      // rate saturates at 1.0 once dt reaches tau (also covers tau of zero)
      f3_m_q       <= '{op: f2_m_q.op, idx: f2_m_q.idx, x: f2_m_q.x, p: f2_m_q.p,
                        neg: f2_m_q.neg,
                        sat_u: (RDW'(f2_dt_q) >= tu), sat_d: (RDW'(f2_dt_q) >= td)};
      f3_qnum_q    <= (QDW+QW)'({f2_prod_q, 15'b0});
      f3_qden_q    <= QDW'(f2_prod_q) + QDW'(256);
      f3_rnum_q    <= (RDW+QW)'({f2_dt_q, 16'b0});
      f3_tu_q      <= tu;
      f3_td_q      <= td;

      dm_q[0] <= f3_m_q;
      for (int i = 1; i < QW; i++) begin
        dm_q[i] <= dm_q[i-1];
      end

      f4_m_q  <= dm_q[QW-1];
      f4_s_q  <= s_d;
      f4_c_q  <= pmt_pkg::RATE_W'(65536) - s_d;
      f4_ru_q <= ru_d;
      f4_rd_q <= rd_d;

      f5_m_q  <= f4_m_q;
      f5_ku_q <= ku_full[pmt_pkg::K_W-1:0];
      f5_kd_q <= kd_full[pmt_pkg::K_W-1:0];
    end
  end

  pmt_divpipe #(.DW(QDW), .QW(QW)) u_sig_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (f3_qnum_q),
    .den_i (f3_qden_q),
    .quo_o (q_quo)
  );

  pmt_divpipe #(.DW(RDW), .QW(QW)) u_up_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (f3_rnum_q),
    .den_i (f3_tu_q),
    .quo_o (ru_quo)
  );

  pmt_divpipe #(.DW(RDW), .QW(QW)) u_dec_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (f3_rnum_q),
    .den_i (f3_td_q),
    .quo_o (rd_quo)
  );

  assign s_d  = dm_q[QW-1].neg ? (pmt_pkg::RATE_W'(32768) - pmt_pkg::RATE_W'(q_quo))
                               : (pmt_pkg::RATE_W'(32768) + pmt_pkg::RATE_W'(q_quo));
  assign ru_d = dm_q[QW-1].sat_u ? pmt_pkg::RATE_W'(65536) : pmt_pkg::RATE_W'(ru_quo);
  assign rd_d = dm_q[QW-1].sat_d ? pmt_pkg::RATE_W'(65536) : pmt_pkg::RATE_W'(rd_quo);

  assign ku_full = 34'(f4_ru_q) * 34'(f4_s_q);
  assign kd_full = 34'(f4_rd_q) * 34'(f4_c_q);

  assign fo_o = '{valid: f5_v_q, op: f5_m_q.op, idx: f5_m_q.idx, x: f5_m_q.x,
                  p: f5_m_q.p, ku: f5_ku_q, kd: f5_kd_q};

endmodule

[src/pmt_back.sv]
// read, euler update, saturate and write back, with same-entry interlock
module pmt_back #(
  parameter int FIELD_ENTRIES = pmt_pkg::FIELD_ENTRIES_DEF,
  localparam int AW = (FIELD_ENTRIES > 1) ? $clog2(FIELD_ENTRIES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pmt_pkg::front_t                   fi_i,
  output pmt_pkg::ctl_t                     ctl_o,
  output logic [AW-1:0]                     ram_raddr_o,
  input  logic [pmt_pkg::DATA_W-1:0]        ram_rdata_i,
  output logic                              ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic [pmt_pkg::DATA_W-1:0]        ram_wdata_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pmt_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [pmt_pkg::DATA_W-1:0] out_act_o
);

  localparam int IW = pmt_pkg::IDX_W;

  logic adv, hazard, f_inr, f_upd;

  logic                     b1_v_q, b1_upd_q;
  pmt_pkg::op_e             b1_op_q;
  logic [IW-1:0]            b1_idx_q;
  logic signed [15:0]       b1_x_q, b1_p_q;
  logic [pmt_pkg::K_W-1:0]  b1_ku_q, b1_kd_q;
  logic signed [15:0]       a1;
  logic signed [16:0]       diff;

  logic                     b2_v_q, b2_upd_q;
  pmt_pkg::op_e             b2_op_q;
  logic [IW-1:0]            b2_idx_q;
  logic signed [15:0]       b2_p_q, b2_a_q;
  logic signed [33:0]       b2_pul_q;
  logic signed [34:0]       b2_puh_q;
  logic signed [32:0]       b2_pdl_q;
  logic signed [33:0]       b2_pdh_q;
  logic signed [51:0]       up_sum, dn_sum, inner;

  logic                     b3_v_q, b3_upd_q;
  pmt_pkg::op_e             b3_op_q;
  logic [IW-1:0]            b3_idx_q;
  logic signed [15:0]       b3_p_q, b3_a_q;
  logic signed [27:0]       b3_in_q;
  logic signed [43:0]       prod;

  logic                     b4_v_q, b4_upd_q;
  pmt_pkg::op_e             b4_op_q;
  logic [IW-1:0]            b4_idx_q;
  logic signed [15:0]       b4_a_q;
  logic signed [27:0]       b4_ch_q;
  logic signed [28:0]       sum;
  logic signed [15:0]       nv;

  logic                     out_v_q;
  logic [IW-1:0]            out_idx_q;
  logic signed [15:0]       out_act_q;

  assign adv   = !out_v_q || out_ready_i;
  assign f_inr = (32'(fi_i.idx) < 32'(FIELD_ENTRIES));
  assign f_upd = fi_i.valid && (fi_i.op == pmt_pkg::OP_UPDATE) && f_inr;

  // an entry still on its way to write back must not be read again
  assign hazard = f_upd && (
      (b1_v_q && b1_upd_q && (b1_idx_q == fi_i.idx)) ||
      (b2_v_q && b2_upd_q && (b2_idx_q == fi_i.idx)) ||
      (b3_v_q && b3_upd_q && (b3_idx_q == fi_i.idx)) ||
      (b4_v_q && b4_upd_q && (b4_idx_q == fi_i.idx)));

  // read data always belongs to the word held in b1
  assign ram_raddr_o = adv ? AW'(fi_i.idx) : AW'(b1_idx_q);

  assign a1   = $signed(ram_rdata_i);
  assign diff = 17'(b1_x_q) - 17'(a1);

  assign up_sum = (52'(b2_puh_q) <<< 16) + 52'(b2_pul_q);
  assign dn_sum = (52'(b2_pdh_q) <<< 16) + 52'(b2_pdl_q);
  assign inner  = up_sum - dn_sum;

  assign prod = 44'(b3_in_q) * 44'(b3_p_q);

  assign sum = 29'(b4_a_q) + 29'(b4_ch_q);
  always_comb begin
    if (sum > 29'sd32767) begin
      nv = 16'sh7fff;
    end else if (sum < -29'sd32768) begin
      nv = -16'sh8000;
    end else begin
      nv = 16'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q  <= fi_i.valid && !hazard;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      out_v_q <= b4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_op_q  <= fi_i.op;
      b1_upd_q <= (fi_i.op == pmt_pkg::OP_UPDATE) && f_inr;
      b1_idx_q <= fi_i.idx;
      b1_x_q   <= fi_i.x;
      b1_p_q   <= fi_i.p;
      b1_ku_q  <= fi_i.ku;
      b1_kd_q  <= fi_i.kd;

      b2_op_q  <= b1_op_q;
      b2_upd_q <= b1_upd_q;
      b2_idx_q <= b1_idx_q;
      b2_p_q   <= b1_p_q;
      b2_a_q   <= a1;
      b2_pul_q <= 34'(diff) * 34'($signed({1'b0, b1_ku_q[15:0]}));
      b2_puh_q <= 35'(diff) * 35'($signed({1'b0, b1_ku_q[32:16]}));
      b2_pdl_q <= 33'(a1) * 33'($signed({1'b0, b1_kd_q[15:0]}));
      b2_pdh_q <= 34'(a1) * 34'($signed({1'b0, b1_kd_q[32:16]}));

      b3_op_q  <= b2_op_q;
      b3_upd_q <= b2_upd_q;
      b3_idx_q <= b2_idx_q;
      b3_p_q   <= b2_p_q;
      b3_a_q   <= b2_a_q;
      b3_in_q  <= 28'(inner >>> 24);

      b4_op_q  <= b3_op_q;
      b4_upd_q <= b3_upd_q;
      b4_idx_q <= b3_idx_q;
      b4_a_q   <= b3_a_q;
      b4_ch_q  <= 28'(prod >>> 16);

      out_idx_q <= (b4_op_q == pmt_pkg::OP_CLEAR) ? '0 : b4_idx_q;
      out_act_q <= b4_upd_q ? nv : '0;
    end
  end

  assign ram_we_o    = adv && b4_v_q && b4_upd_q;
  assign ram_waddr_o = AW'(b4_idx_q);
  assign ram_wdata_o = nv;

  assign ctl_o.adv      = adv;
  assign ctl_o.hazard   = hazard;
  assign ctl_o.clr_done = adv && b4_v_q && (b4_op_q == pmt_pkg::OP_CLEAR);

  assign out_valid_o = out_v_q;
  assign out_index_o = out_idx_q;
  assign out_act_o   = out_act_q;

endmodule

[src/preshape_memory_trace_update.sv]
// top level of the preshape memory trace update block
//
//  channel  dir  handshake      word
//  in_i     in   valid/ready    op, entry_index, input_value, peak_gain, step_time_us
//  out_o    out  valid/ready    result_index, new_activation
//  cfg_i    in   valid/ready    index, data (register write, always ready)
//
// one word per cycle when consecutive updates hit different entries and the output is not stalled;
// the pipeline has 22 sigmoid/rate stages with three 16-stage dividers, 4 update stages, output register
// an update to an entry still in the read to write-back loop is held until that entry is written back
// after reset, and after a clear word, a sweep zeroes the store
// while no word is taken; register writes are taken at any time
// a stalled output freezes the whole pipeline, nothing is lost or repeated
module preshape_memory_trace_update #(
  parameter int FIELD_ENTRIES = pmt_pkg::FIELD_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmt_in_if.sink    in_i,
  pmt_out_if.source out_o,
  pmt_cfg_if.sink   cfg_i
);

  localparam int AW = (FIELD_ENTRIES > 1) ? $clog2(FIELD_ENTRIES) : 1;

  pmt_pkg::cfg_t   cfg_q;
  pmt_pkg::front_t fo;
  pmt_pkg::ctl_t   ctl;

  logic          in_acc, busy;
  logic          clr_pend_q, sweep_q;
  logic [AW-1:0] swp_cnt_q;

  logic          ram_we, back_we;
  logic [AW-1:0] ram_waddr, back_waddr, ram_raddr;
  logic [15:0]   ram_wdata, back_wdata, ram_rdata;

  // register file, unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.build_up  <= pmt_pkg::BUILD_UP_RST;
      cfg_q.decay     <= pmt_pkg::DECAY_RST;
      cfg_q.threshold <= $signed(pmt_pkg::THRESHOLD_RST);
      cfg_q.steepness <= pmt_pkg::STEEPNESS_RST;
    end else if (cfg_i.valid) begin
      case (pmt_pkg::cfg_reg_e'(cfg_i.index))
        pmt_pkg::REG_BUILD_UP:  cfg_q.build_up  <= cfg_i.data;
        pmt_pkg::REG_DECAY:     cfg_q.decay     <= cfg_i.data;
        pmt_pkg::REG_THRESHOLD: cfg_q.threshold <= $signed(cfg_i.data);
        pmt_pkg::REG_STEEPNESS: cfg_q.steepness <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input is held off from a clear word until its sweep is over
  assign busy        = clr_pend_q || sweep_q;
  assign in_i.ready  = ctl.adv && !ctl.hazard && !busy;
  assign in_acc      = in_i.valid && in_i.ready;

  // clearing sweep: starts out of reset and when a clear word leaves the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_pend_q <= 1'b0;
      sweep_q    <= 1'b1;
      swp_cnt_q  <= '0;
    end else begin
      if (in_acc && (pmt_pkg::op_e'(in_i.op) == pmt_pkg::OP_CLEAR)) begin
        clr_pend_q <= 1'b1;
      end
      if (ctl.clr_done) begin
        clr_pend_q <= 1'b0;
        sweep_q    <= 1'b1;
        swp_cnt_q  <= '0;
      end else if (sweep_q) begin
        if (swp_cnt_q == AW'(FIELD_ENTRIES - 1)) begin
          sweep_q <= 1'b0;
        end else begin
          swp_cnt_q <= swp_cnt_q + AW'(1);
        end
      end
    end
  end

  pmt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (ctl.adv && !ctl.hazard),
    .in_valid_i (in_acc),
    .in_op_i    (pmt_pkg::op_e'(in_i.op)),
    .in_idx_i   (in_i.entry_index),
    .in_x_i     (in_i.input_value),
    .in_p_i     (in_i.peak_gain),
    .in_dt_i    (in_i.step_time_us),
    .cfg_i      (cfg_q),
    .fo_o       (fo)
  );

  pmt_back #(.FIELD_ENTRIES(FIELD_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fi_i        (fo),
    .ctl_o       (ctl),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (back_we),
    .ram_waddr_o (back_waddr),
    .ram_wdata_o (back_wdata),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_index_o (out_o.result_index),
    .out_act_o   (out_o.new_activation)
  );

  // sweep and write-back never overlap: the pipeline is empty during a sweep
  assign ram_we    = sweep_q || back_we;
  assign ram_waddr = sweep_q ? swp_cnt_q : back_waddr;
  assign ram_wdata = sweep_q ? '0 : back_wdata;

  pmt_ram #(.WIDTH(pmt_pkg::DATA_W), .DEPTH(FIELD_ENTRIES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_no_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep_q && back_we))
    else $error("write-back during clearing sweep");

  a_clear_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr_done |-> clr_pend_q)
    else $error("clear left the pipeline without being accepted");

  a_sweep_blocks_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !fo.valid)
    else $error("word in flight while store is being cleared");

endmodule

[dv/pmt_checker.sv]
// checker: watches the update, result and register channels, predicts and compares results
`timescale 1ns / 1ps
module pmt_checker
  import pmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pmt_in_if          in_ch,
  pmt_out_if         out_ch,
  pmt_cfg_if         cfg_ch,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] act;
  } trace_word_t;

  logic signed [DATA_W-1:0] trace_mem [FIELD_ENTRIES_DEF];
  cfg_t                     cur_cfg;
  trace_word_t              expected_q [$];

  // rate dt/tau in unsigned q0.16, capped at 1.0
  function automatic longint rate_q16(longint dt_us, longint tau_ms);
    longint r;
    if (tau_ms == 0) return 65536;
    r = (dt_us << 16) / (tau_ms * 1000);
    return (r > 65536) ? 65536 : r;
  endfunction

  // floor division by 2^k for signed values
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic trace_word_t predict_update(logic [IDX_W-1:0] idx,
                                                 logic signed [DATA_W-1:0] x_in,
                                                 logic signed [DATA_W-1:0] p_in,
                                                 logic [TIME_W-1:0] dt);
    trace_word_t w;
    longint x, p, t, d, m, q, s, a, ru, rd, inner, chg, nv;
    x = x_in;
    p = p_in;
    t = cur_cfg.threshold;
    d = x - t;
    m = longint'(cur_cfg.steepness) * ((d < 0) ? -d : d);
    q = (m * 32768) / (256 + m);
    s = (d >= 0) ? 32768 + q : 32768 - q;
    ru = rate_q16(dt, cur_cfg.build_up);
    rd = rate_q16(dt, cur_cfg.decay);
    a = trace_mem[idx];
    inner = (x - a) * (ru * s) - a * (rd * (65536 - s));
    inner = floor_shr(inner, 24);
    chg = floor_shr(inner * p, 16);
    nv = a + chg;
    if (nv > 32767) nv = 32767;
    if (nv < -32768) nv = -32768;
    trace_mem[idx] = DATA_W'(nv);
    w.idx = idx;
    w.act = DATA_W'(nv);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trace_word_t exp_w;
    if (!rst_ni) begin
      cur_cfg <= '{build_up: BUILD_UP_RST, decay: DECAY_RST,
                   threshold: THRESHOLD_RST, steepness: STEEPNESS_RST};
      foreach (trace_mem[i]) trace_mem[i] = '0;
      expected_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_e'(cfg_ch.index))
          REG_BUILD_UP:  cur_cfg.build_up  <= cfg_ch.data;
          REG_DECAY:     cur_cfg.decay     <= cfg_ch.data;
          REG_THRESHOLD: cur_cfg.threshold <= cfg_ch.data;
          REG_STEEPNESS: cur_cfg.steepness <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (op_e'(in_ch.op) == OP_CLEAR) begin
          foreach (trace_mem[i]) trace_mem[i] = '0;
          expected_q.push_back('{idx: '0, act: '0});
        end else begin
          expected_q.push_back(predict_update(in_ch.entry_index, in_ch.input_value,
                                              in_ch.peak_gain, in_ch.step_time_us));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: idx %0d act %0d", out_ch.result_index,
                     out_ch.new_activation);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w.idx !== out_ch.result_index || exp_w.act !== out_ch.new_activation) begin
            if (fail_count < 10)
              $display("mismatch: expected idx %0d act %0d, got idx %0d act %0d",
                       exp_w.idx, exp_w.act, out_ch.result_index, out_ch.new_activation);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

[dv/tb.sv]
// testbench top: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb;
  import pmt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_count;

  // gap percentages, changed per phase
  int   send_idle_pct = 7;
  int   recv_idle_pct = 76;
  bit   recv_hold = 1'b0;

  pmt_in_if  in_ch ();
  pmt_out_if out_ch ();
  pmt_cfg_if cfg_ch ();

  preshape_memory_trace_update u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  pmt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while pressure is on
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_UPDATE;
    in_ch.entry_index = '0;
    in_ch.input_value = '0;
    in_ch.peak_gain = '0;
    in_ch.step_time_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // offer one word, with a random gap first, and wait for it to be taken
  // valid stays high afterwards so words can follow back to back
  task automatic send_word(op_e op, logic [IDX_W-1:0] idx, logic [15:0] x,
                           logic [15:0] p, logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.entry_index <= idx;
    in_ch.input_value <= x;
    in_ch.peak_gain <= p;
    in_ch.step_time_us <= dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering, wait until every expected word has come back, then let the pipeline drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] bu, logic [15:0] dc, logic [15:0] th,
                          logic [15:0] st);
    write_reg(REG_BUILD_UP, bu);
    write_reg(REG_DECAY, dc);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_STEEPNESS, st);
  endtask

  // mostly small indexes so entries get revisited, sometimes the full range
  function automatic logic [IDX_W-1:0] pick_index();
    return ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(15));
  endfunction

  task automatic random_words(int n);
    logic [15:0] x, p, dt;
    for (int i = 0; i < n; i++) begin
      x = $urandom;
      p = $urandom;
      dt = ($urandom_range(1) == 0) ? 16'($urandom_range(2000)) : 16'($urandom);
      if ($urandom_range(3) == 0) x = 16'($signed(x) >>> 6);
      send_word(($urandom_range(199) == 0) ? OP_CLEAR : OP_UPDATE, pick_index(), x, p, dt);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, default registers
    send_word(OP_UPDATE, 12'd0, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(OP_UPDATE, 12'd0, 16'h8000, 16'h7fff, 16'hffff);
    send_word(OP_UPDATE, 12'd4095, 16'h8000, 16'h8000, 16'hffff);
    send_word(OP_UPDATE, 12'd4095, 16'h7fff, 16'h8000, 16'd0);
    send_word(OP_UPDATE, 12'd1, 16'h0080, 16'h0100, 16'd5000);
    send_word(OP_UPDATE, 12'd1, 16'h0100, 16'h0100, 16'd5000);
    send_word(OP_UPDATE, 12'd2, 16'h0000, 16'h0100, 16'd1);
    send_word(OP_UPDATE, 12'd1, 16'h0100, 16'hff00, 16'd50000);
    send_word(OP_CLEAR, 12'hfff, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(OP_UPDATE, 12'd0, 16'h0040, 16'h0100, 16'd10000);
    drain();

    // zero time scales saturate both rates, extreme threshold and steepness
    set_regs(16'd0, 16'd0, 16'h8000, 16'hffff);
    send_word(OP_UPDATE, 12'd3, 16'h7fff, 16'h0100, 16'd1);
    send_word(OP_UPDATE, 12'd3, 16'h8000, 16'h0100, 16'd1);
    send_word(OP_UPDATE, 12'd4, 16'h0000, 16'h7fff, 16'd0);
    drain();
    set_regs(16'hffff, 16'hffff, 16'h7fff, 16'd0);
    send_word(OP_UPDATE, 12'd3, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(OP_UPDATE, 12'd5, 16'h8000, 16'h8000, 16'hffff);
    send_word(OP_UPDATE, 12'd3, 16'h1234, 16'h0100, 16'd100);
    drain();
    // register index outside the map is ignored
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_IDX_W'(REG_STEEPNESS) + 1'b1;
    cfg_ch.data <= 16'h5a5a;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);

    // random phase one: sender rarely idles, receiver mostly stalls
    set_regs(16'd1, 16'd10, 16'h0080, 16'd1000);
    random_words(550);
    drain();

    // pressure: receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      random_words(60);
      begin
        repeat (300) @(negedge clk_i);
        recv_hold = 1'b0;
      end
    join
    drain();

    // random phase two: roles swapped
    send_idle_pct = 76;
    recv_idle_pct = 7;
    set_regs(16'd100, 16'd1000, 16'hff00, 16'd20);
    random_words(500);
    drain();

    // random phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
             16'($urandom), 16'($urandom));
    random_words(300);
    drain();
    set_regs(16'd2, 16'd3, 16'h0000, 16'd1);
    random_words(300);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // stalls at 76 percent with full-store clearing sweeps: generous bound
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
